@@ rtl/clie_pkg.sv @@
`timescale 1ns / 1ps
package clie_pkg;

    localparam int CAPACITY_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    typedef enum logic [2:0] {
        K_PUSH_FRONT = 3'd0,
        K_PUSH_BACK  = 3'd1,
        K_POP_FRONT  = 3'd2,
        K_POP_BACK   = 3'd3,
        K_DELETE     = 3'd4,
        K_INS_BEFORE = 3'd5,
        K_INS_AFTER  = 3'd6,
        K_DUMP       = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK,
        S_UNLINK_RD,
        S_UNLINK_P,
        S_UNLINK_N,
        S_INS_RD,
        S_INS_A,
        S_INS_B,
        S_DUMP_RD,
        S_DUMP_OUT,
        S_RESULT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the accepted beat
        logic walk_start;  // cursor <= head
        logic walk_step;   // cursor <= next[cursor], index++
        logic cur_tail;    // cursor <= prev[head]
        logic rd_cursor;   // read node at cursor
        logic unl_p;       // next[prev] <= next
        logic unl_n;       // prev[next] <= prev, free slot, count--
        logic ins_rd;      // allocate and read neighbor links
        logic ins_a;       // write new node links and value
        logic ins_b;       // patch neighbor links, count++
        logic res_val;     // result value from read data
        logic set_res;     // latch status, result value and last flag
        t_status status;
        logic dump_step;   // cursor to next, index++
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic pos_bad;     // position at or past count
        logic walk_done;   // index equals target
        logic dump_last;   // current dump element is the tail
        t_kind kind;
        logic pos_zero;
    } t_sts;

endpackage

@@ rtl/clie_if.sv @@
`timescale 1ns / 1ps
interface clie_in_if;
    import clie_pkg::*;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic signed [31:0] value;
    logic [5:0]  position;
    modport source (output valid, kind, value, position, input ready);
    modport sink   (input valid, kind, value, position, output ready);
endinterface

interface clie_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic signed [31:0] value_res;
    logic        last;
    modport source (output valid, status, value_res, last, input ready);
    modport sink   (input valid, status, value_res, last, output ready);
endinterface

@@ rtl/clie_datapath.sv @@
`timescale 1ns / 1ps
module clie_datapath
    import clie_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic [2:0]           i_kind,
    input  logic signed [31:0]   i_value,
    input  logic [5:0]           i_position,
    output logic [1:0]           o_status,
    output logic signed [31:0]   o_value_res,
    output logic                 o_last
);
    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [VALUE_BITS-1:0] r_vals [CAPACITY];
    logic [SW-1:0]         r_next [CAPACITY];
    logic [SW-1:0]         r_prev [CAPACITY];

    logic [SW-1:0]  r_head;
    logic [CW-1:0]  r_count;
    logic [CAPACITY-1:0] r_free;
    logic [2:0]     r_kind;
    logic [VALUE_BITS-1:0] r_val;
    logic [5:0]     r_pos;
    logic [5:0]     r_target;
    logic [5:0]     r_idx;
    logic [SW-1:0]  r_cur;
    logic [SW-1:0]  r_new;
    logic [SW-1:0]  r_at;      // node the new one goes before
    logic [SW-1:0]  r_rd_n;
    logic [SW-1:0]  r_rd_p;
    logic [VALUE_BITS-1:0] r_rd_v;
    logic [SW-1:0]  r_head_tail;
    logic [1:0]     r_status;
    logic [31:0]    r_res;
    logic           r_last;
    logic           r_make_head;
    logic           r_was_empty;

    logic [SW-1:0]  n_free_slot;
    logic [VALUE_BITS-1:0] n_sval;
    logic [63:0]    w_ext;

    always_comb begin
        n_free_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                n_free_slot = SW'(i);
            end
        end
    end

    always_comb begin
        w_ext  = {{32{i_value[31]}}, i_value};
        n_sval = w_ext[VALUE_BITS-1:0];
    end

    function automatic logic [31:0] out_form(input logic [VALUE_BITS-1:0] v);
        logic [63:0] e;
        e = {{(64-VALUE_BITS){v[VALUE_BITS-1]}}, v};
        return e[31:0];
    endfunction

    always_comb begin
        o_sts.full      = (r_count == CW'(CAPACITY));
        o_sts.empty     = (r_count == '0);
        o_sts.pos_bad   = ({1'b0, r_pos} >= 7'(r_count));
        o_sts.walk_done = (r_idx == r_target);
        o_sts.dump_last = ({1'b0, r_idx} + 7'd1 == 7'(r_count));
        o_sts.kind      = t_kind'(r_kind);
        o_sts.pos_zero  = (r_pos == '0);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_free  <= '1;
        end else begin
            if (i_cmd.unl_n) begin
                r_free[r_cur] <= 1'b1;
                r_count <= r_count - CW'(1);
                if (r_count == CW'(1)) begin
                    r_head <= '0;
                end else if (r_cur == r_head) begin
                    r_head <= r_rd_n;
                end
            end
            if (i_cmd.ins_rd) begin
                r_free[n_free_slot] <= 1'b0;
            end
            if (i_cmd.ins_b) begin
                r_count <= r_count + CW'(1);
                if (r_was_empty || r_make_head) begin
                    r_head <= r_new;
                end
            end
        end
    end

    // Memories and payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_val  <= n_sval;
            r_pos  <= i_position;
        end
        if (i_cmd.walk_start) begin
            r_cur <= r_head;
            r_idx <= '0;
            r_target <= r_pos;
        end
        if (i_cmd.cur_tail) begin
            r_cur <= r_prev[r_head];
            r_idx <= '0;
        end
        if (i_cmd.walk_step || i_cmd.dump_step) begin
            r_cur <= r_next[r_cur];
            r_idx <= r_idx + 6'd1;
        end
        if (i_cmd.rd_cursor) begin
            r_rd_n <= r_next[r_cur];
            r_rd_p <= r_prev[r_cur];
            r_rd_v <= r_vals[r_cur];
        end
        if (i_cmd.unl_p) begin
            r_next[r_rd_p] <= r_rd_n;
        end
        if (i_cmd.unl_n) begin
            r_prev[r_rd_n] <= r_rd_p;
        end
        if (i_cmd.ins_rd) begin
            // r_cur holds the node to insert before.
            r_new       <= n_free_slot;
            r_at        <= r_cur;
            r_head_tail <= r_prev[r_cur];
            r_was_empty <= (r_count == '0);
        end
        if (i_cmd.ins_a) begin
            r_vals[r_new] <= r_val;
            r_next[r_new] <= r_was_empty ? r_new : r_at;
            r_prev[r_new] <= r_was_empty ? r_new : r_head_tail;
        end
        if (i_cmd.ins_b && !r_was_empty) begin
            r_next[r_head_tail] <= r_new;
            r_prev[r_at]        <= r_new;
        end
        if (i_cmd.load) begin
            r_make_head <= (t_kind'(i_kind) == K_PUSH_FRONT);
        end
        if (i_cmd.set_res) begin
            r_status <= i_cmd.status;
            r_res    <= i_cmd.res_val ? out_form(r_rd_v) : '0;
            r_last   <= (t_kind'(r_kind) != K_DUMP) || o_sts.dump_last
                        || (i_cmd.status != ST_OK);
        end
        if (i_cmd.walk_start && t_kind'(r_kind) == K_INS_BEFORE) begin
            r_make_head <= (r_pos == '0);
        end
    end

    assign o_status    = r_status;
    assign o_value_res = r_res;
    assign o_last      = r_last;
endmodule

@@ rtl/clie_ctrl.sv @@
`timescale 1ns / 1ps
module clie_ctrl
    import clie_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    t_state r_state, n_state;
    logic   r_dump;  // result belongs to a dump with more to come
    logic   n_dump;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dump  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dump  <= n_dump;
        end
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.status = ST_OK;
        n_state     = r_state;
        n_dump      = r_dump;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_WALK;
                end
            end
            S_WALK: begin
                // This state decides the operation; any link walk happens in S_DUMP_RD.
                n_state = S_RESULT;
                o_cmd.set_res = 1'b1;
                case (i_sts.kind)
                    K_PUSH_FRONT, K_PUSH_BACK: begin
                        if (i_sts.full) begin
                            o_cmd.status = ST_FULL;
                        end else begin
                            o_cmd.set_res = 1'b0;
                            o_cmd.walk_start = 1'b1;
                            n_state = S_INS_RD;
                        end
                    end
                    K_POP_FRONT, K_POP_BACK: begin
                        if (i_sts.empty) begin
                            o_cmd.status = ST_EMPTY;
                        end else begin
                            o_cmd.set_res = 1'b0;
                            if (i_sts.kind == K_POP_FRONT) o_cmd.walk_start = 1'b1;
                            else o_cmd.cur_tail = 1'b1;
                            n_state = S_UNLINK_RD;
                        end
                    end
                    K_DELETE: begin
                        if (i_sts.empty) o_cmd.status = ST_EMPTY;
                        else if (i_sts.pos_bad) o_cmd.status = ST_BADPOS;
                        else begin
                            o_cmd.set_res = 1'b0;
                            o_cmd.walk_start = 1'b1;
                            n_state = S_DUMP_RD;
                        end
                    end
                    K_INS_BEFORE: begin
                        if (i_sts.full) o_cmd.status = ST_FULL;
                        else if (!i_sts.empty && !i_sts.pos_zero && i_sts.pos_bad)
                            o_cmd.status = ST_BADPOS;
                        else begin
                            o_cmd.set_res = 1'b0;
                            o_cmd.walk_start = 1'b1;
                            n_state = (i_sts.empty || i_sts.pos_zero) ? S_INS_RD
                                                                      : S_DUMP_RD;
                        end
                    end
                    K_INS_AFTER: begin
                        if (i_sts.empty) o_cmd.status = ST_EMPTY;
                        else if (i_sts.full) o_cmd.status = ST_FULL;
                        else if (i_sts.pos_bad) o_cmd.status = ST_BADPOS;
                        else begin
                            o_cmd.set_res = 1'b0;
                            o_cmd.walk_start = 1'b1;
                            n_state = S_DUMP_RD;
                        end
                    end
                    default: begin
                        if (i_sts.empty) o_cmd.status = ST_EMPTY;
                        else begin
                            o_cmd.set_res = 1'b0;
                            o_cmd.walk_start = 1'b1;
                            n_state = S_DUMP_RD;
                        end
                    end
                endcase
            end
            S_DUMP_RD: begin
                // Dump reads the cursor; other kinds walk until the index matches the target.
                if (i_sts.kind == K_DUMP) begin
                    o_cmd.rd_cursor = 1'b1;
                    n_state = S_DUMP_OUT;
                end else if (!i_sts.walk_done) begin
                    o_cmd.walk_step = 1'b1;
                end else if (i_sts.kind == K_DELETE) begin
                    o_cmd.rd_cursor = 1'b1;
                    n_state = S_UNLINK_P;
                end else if (i_sts.kind == K_INS_AFTER) begin
                    o_cmd.walk_step = 1'b1;
                    n_state = S_INS_RD;
                end else begin
                    n_state = S_INS_RD;
                end
            end
            S_DUMP_OUT: begin
                o_cmd.set_res = 1'b1;
                o_cmd.res_val = 1'b1;
                n_dump  = !i_sts.dump_last;
                n_state = S_RESULT;
            end
            S_UNLINK_RD: begin
                o_cmd.rd_cursor = 1'b1;
                n_state = S_UNLINK_P;
            end
            S_UNLINK_P: begin
                o_cmd.unl_p = 1'b1;
                n_state = S_UNLINK_N;
            end
            S_UNLINK_N: begin
                o_cmd.unl_n   = 1'b1;
                o_cmd.set_res = 1'b1;
                o_cmd.res_val = 1'b1;
                n_state = S_RESULT;
            end
            S_INS_RD: begin
                o_cmd.ins_rd = 1'b1;
                n_state = S_INS_A;
            end
            S_INS_A: begin
                o_cmd.ins_a = 1'b1;
                n_state = S_INS_B;
            end
            S_INS_B: begin
                o_cmd.ins_b   = 1'b1;
                o_cmd.set_res = 1'b1;
                n_state = S_RESULT;
            end
            S_RESULT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (r_dump) begin
                        o_cmd.dump_step = 1'b1;
                        n_dump  = 1'b0;
                        n_state = S_DUMP_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

@@ rtl/circular_list_index_engine.sv @@
`timescale 1ns / 1ps
// Status-only results are set while the operation is decoded; pushes, pops and insert before
// at position 0 go straight to the link read and write states; delete, insert after and other
// inserts before first walk the links from the head (up to CAPACITY-1 links).
// Dump follows the next links, one element per result beat, and waits for each beat to be taken.
// One item at a time; the next is taken from the cycle after the last result beat is delivered.
// Synchronous active-low reset empties the list and frees every slot.
module circular_list_index_engine
    import clie_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    clie_in_if.sink    i_in,
    clie_out_if.source o_out
);
    t_cmd w_cmd;
    t_sts w_sts;

    clie_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    clie_datapath #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_kind      (i_in.kind),
        .i_value     (i_in.value),
        .i_position  (i_in.position),
        .o_status    (o_out.status),
        .o_value_res (o_out.value_res),
        .o_last      (o_out.last)
    );
endmodule

@@ tb/clie_list_checker.sv @@
`timescale 1ns / 1ps
module clie_list_checker
    import clie_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    clie_in_if.sink    i_in,
    clie_out_if.sink   i_out,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_results_seen
);

    typedef struct packed {
        t_status     status;
        logic [31:0] value;
        logic        last;
    } t_list_beat;

    // The list is mirrored as an ordered array of values; slots do not matter outside.
    logic [31:0] list_words[$];
    t_list_beat  beats_due[$];
    int          fails = 0;
    int          seen = 0;

    assign o_fail_count   = fails;
    assign o_pending      = beats_due.size();
    assign o_results_seen = seen;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        fails++;
    endtask

    function automatic t_list_beat mk(input t_status s, input logic [31:0] v, input logic l);
        t_list_beat b;
        b.status = s;
        b.value  = v;
        b.last   = l;
        return b;
    endfunction

    task automatic apply_operation(input t_kind kind, input logic [31:0] value,
                                   input logic [5:0] position);
        int n;
        logic [31:0] w;
        n = list_words.size();
        case (kind)
            K_PUSH_FRONT, K_PUSH_BACK: begin
                if (n >= CAPACITY) begin
                    beats_due.push_back(mk(ST_FULL, '0, 1'b1));
                end else begin
                    if (kind == K_PUSH_FRONT) list_words.push_front(value);
                    else list_words.push_back(value);
                    beats_due.push_back(mk(ST_OK, '0, 1'b1));
                end
            end
            K_POP_FRONT, K_POP_BACK, K_DELETE: begin
                if (n == 0) begin
                    beats_due.push_back(mk(ST_EMPTY, '0, 1'b1));
                end else if (kind == K_DELETE && position >= n) begin
                    beats_due.push_back(mk(ST_BADPOS, '0, 1'b1));
                end else begin
                    if (kind == K_POP_FRONT) w = list_words.pop_front();
                    else if (kind == K_POP_BACK) w = list_words.pop_back();
                    else begin
                        w = list_words[position];
                        list_words.delete(int'(position));
                    end
                    beats_due.push_back(mk(ST_OK, w, 1'b1));
                end
            end
            K_INS_BEFORE: begin
                if (n >= CAPACITY) beats_due.push_back(mk(ST_FULL, '0, 1'b1));
                else if (n != 0 && position != 0 && position >= n)
                    beats_due.push_back(mk(ST_BADPOS, '0, 1'b1));
                else begin
                    if (n == 0) list_words.push_front(value);
                    else list_words.insert(int'(position), value);
                    beats_due.push_back(mk(ST_OK, '0, 1'b1));
                end
            end
            K_INS_AFTER: begin
                if (n == 0) beats_due.push_back(mk(ST_EMPTY, '0, 1'b1));
                else if (n >= CAPACITY) beats_due.push_back(mk(ST_FULL, '0, 1'b1));
                else if (position >= n) beats_due.push_back(mk(ST_BADPOS, '0, 1'b1));
                else begin
                    list_words.insert(int'(position) + 1, value);
                    beats_due.push_back(mk(ST_OK, '0, 1'b1));
                end
            end
            default: begin
                if (n == 0) beats_due.push_back(mk(ST_EMPTY, '0, 1'b1));
                else
                    for (int i = 0; i < n; i++)
                        beats_due.push_back(mk(ST_OK, list_words[i], i == n - 1));
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_list_beat want;
        if (!i_rst_n) begin
            list_words.delete();
            beats_due.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                seen++;
                if (beats_due.size() == 0) begin
                    report("unexpected beat", i_out.value_res, '0);
                end else begin
                    want = beats_due.pop_front();
                    if (i_out.status !== want.status)
                        report("status", 32'(i_out.status), 32'(want.status));
                    if (i_out.value_res !== want.value)
                        report("value_res", i_out.value_res, want.value);
                    if (i_out.last !== want.last)
                        report("last", 32'(i_out.last), 32'(want.last));
                end
            end
            if (i_in.valid && i_in.ready)
                apply_operation(t_kind'(i_in.kind), i_in.value, i_in.position);
        end
    end

endmodule

@@ tb/circular_list_index_engine_tb.sv @@
`timescale 1ns / 1ps
module circular_list_index_engine_tb;
    import clie_pkg::*;

    localparam int CAP = 32;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   results_seen;
    int   ops_sent;
    int   kind_hits[8];
    bit   stall_long;
    bit   rand_stall;

    clie_in_if  in_ch ();
    clie_out_if out_ch ();

    circular_list_index_engine #(.CAPACITY(CAP), .VALUE_BITS(32)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    clie_list_checker #(.CAPACITY(CAP)) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (in_ch.sink),
        .i_out          (out_ch.sink),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Sends one beat and holds it until the block takes it.
    task automatic send_op(input t_kind kind, input logic [31:0] value, input logic [5:0] pos);
        in_ch.valid    <= 1'b1;
        in_ch.kind     <= kind;
        in_ch.value    <= value;
        in_ch.position <= pos;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        ops_sent++;
        kind_hits[kind]++;
    endtask

    task automatic go_idle(input int cycles);
        in_ch.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Receiver ready: random stalls or a forced long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else if (stall_long) out_ch.ready <= 1'b0;
        else if (rand_stall) out_ch.ready <= ($urandom_range(0, 3) != 0);
        else out_ch.ready <= 1'b1;
    end

    initial begin
        int burst;
        int cnt;
        t_kind k;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.kind      = '0;
        in_ch.value     = '0;
        in_ch.position  = '0;
        stall_long      = 1'b0;
        rand_stall      = 1'b0;
        ops_sent        = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-list cases, then extremes and every operation.
        send_op(K_POP_FRONT, '0, '0);
        send_op(K_POP_BACK, '0, '0);
        send_op(K_DELETE, '0, 6'd0);
        send_op(K_INS_AFTER, 32'h5, 6'd0);
        send_op(K_DUMP, '0, '0);
        send_op(K_INS_BEFORE, 32'h8000_0000, 6'd63);
        send_op(K_PUSH_FRONT, 32'h7FFF_FFFF, 6'd0);
        send_op(K_PUSH_BACK, 32'hFFFF_FFFF, 6'd0);
        send_op(K_INS_BEFORE, 32'h1234, 6'd0);
        send_op(K_INS_BEFORE, 32'h55AA, 6'd2);
        send_op(K_INS_BEFORE, 32'h1, 6'd4);
        send_op(K_INS_AFTER, 32'hAAAA_5555, 6'd3);
        send_op(K_INS_AFTER, 32'h2, 6'd5);
        send_op(K_INS_AFTER, 32'h3, 6'd63);
        send_op(K_DUMP, '0, '0);
        send_op(K_DELETE, '0, 6'd63);
        send_op(K_DELETE, '0, 6'd2);
        send_op(K_POP_BACK, '0, '0);
        send_op(K_POP_FRONT, '0, '0);
        send_op(K_DUMP, '0, '0);
        wait_drained();

        // Fill the pool and overflow it, with the receiver holding off at first.
        stall_long <= 1'b1;
        fork
            begin
                for (int i = 0; i < CAP + 2; i++)
                    send_op(($urandom_range(0, 1) != 0) ? K_PUSH_BACK : K_PUSH_FRONT,
                            rand_word(), '0);
                send_op(K_INS_BEFORE, 32'h9, 6'd63);
                send_op(K_INS_AFTER, 32'h9, 6'd63);
                send_op(K_DUMP, '0, '0);
                in_ch.valid <= 1'b0;
            end
            begin
                repeat (300) @(posedge i_clk);
                stall_long <= 1'b0;
            end
        join
        wait_drained();

        rand_stall <= 1'b1;
        cnt = 0;
        while (cnt < 290) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++) begin
                // Lean toward growth or shrinkage in turns to visit full and empty.
                if ((cnt / 60) % 2 == 0)
                    k = t_kind'($urandom_range(0, 9) < 6 ?
                        ($urandom_range(0, 1) ? K_PUSH_BACK : K_INS_AFTER + 0) :
                        $urandom_range(0, 7));
                else
                    k = t_kind'($urandom_range(0, 9) < 6 ? $urandom_range(2, 4) :
                        $urandom_range(0, 7));
                if (k == K_DUMP && $urandom_range(0, 3) != 0) k = K_INS_BEFORE;
                send_op(k, rand_word(),
                        ($urandom_range(0, 7) == 0) ? 6'($urandom_range(32, 63))
                                                    : 6'($urandom_range(0, 31)));
                cnt++;
            end
            if ($urandom_range(0, 2) == 0) begin
                if ($urandom_range(0, 5) == 0) rand_stall <= ~rand_stall;
                go_idle($urandom_range(1, 40));
            end
        end
        wait_drained();
        repeat (100) @(posedge i_clk);

        $display("Sent %0d operations, checked %0d result beats.", ops_sent, results_seen);
        $display("Pool filled past capacity, drained to empty, all eight kinds issued.");
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
